// File: rtl/tcw_pkg.sv
// Package for the text console writer: screen geometry, cell codes,
// operation codes and the cursor-to-cell index function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int MOVE_COUNT  = CELL_COUNT - SCREEN_COLS;

    // Field widths of the stream words
    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int OFF_W  = 11;
    localparam int CELL_W = 2 * BYTE_W;

    // Store addressing: ADDR_W indexes a cell, IDX_W also holds the cell count
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int IDX_W  = $clog2(CELL_COUNT + 1);

    // Cell codes
    localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [BYTE_W-1:0] NULL_CODE    = 8'h00;
    localparam logic [BYTE_W-1:0] SCROLL_ATTR  = 8'h1F;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR = 2'd0,
        OP_GOTO     = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_READ     = 2'd3
    } t_op;

    // Linear cell index of a cursor position: row * width + column
    function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return IDX_W'(row) * IDX_W'(SCREEN_COLS) + IDX_W'(col);
    endfunction

endpackage

`default_nettype wire

// File: rtl/tcw_ram.sv
// Generic single-clock RAM: one write port, one read port with registered
// read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry and read one entry into the registered read data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/text_console_writer.sv
// Text console writer top level: screen store, cursor and command sequencer.
// Depends on tcw_pkg and tcw_ram.
//
// Commands enter on s_axis, one word per operation (put_char, goto, clear,
// read cell); each returns one result word on m_axis with the cursor, its
// linear offset, a scroll flag and the read cell. The print attribute is
// loaded through i_cfg_wr_en / i_cfg_wr_data; the user must load it only
// while no command is in flight, which the block itself does not enforce.
// Goto, newline without scroll, null code and out-of-range read go straight
// to the result; a printable character passes through the put state and an
// in-range read through the read state. A scroll first copies each cell up
// one row, then blanks the bottom row; clear writes every cell in turn.
// The next command is taken once the sequencer is back in idle, so the block
// takes no new command before the last one has loaded its result; the single
// write port of the screen store sets the scroll and clear lengths.
// After reset the sequencer zeroes the store, one cell a cycle, with
// s_axis_tready low; configuration writes are taken throughout. A stalled
// result is held in the output register; the next command is still accepted
// and runs up to its result, which then waits.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: text attribute
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    // Command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] operation, [9:2] data_byte, [16:10] target_col, [21:17] target_row
    input  wire logic [23:0] s_axis_tdata,
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_offset,
    // [23] scrolled, [31:24] read_char, [39:32] read_attr
    output logic      [39:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL,
        S_FILL,
        S_PUT,
        S_CLEAR,
        S_READ,
        S_DONE
    } t_state;

    localparam logic [COL_W-1:0]  LAST_COLS = COL_W'(SCREEN_COLS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [IDX_W-1:0]  IDX_MOVE  = IDX_W'(MOVE_COUNT);
    localparam logic [IDX_W-1:0]  IDX_COLS  = IDX_W'(SCREEN_COLS);
    localparam logic [IDX_W-1:0]  IDX_FLAST = IDX_W'(SCREEN_COLS - 1);
    localparam logic [IDX_W-1:0]  IDX_CLAST = IDX_W'(CELL_COUNT - 1);
    localparam logic [CELL_W-1:0] SCROLL_WORD = {SCROLL_ATTR, SPACE_CODE};

    // Command word fields
    t_op              in_op;
    logic [BYTE_W-1:0] in_data;
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;

    assign in_op   = t_op'(s_axis_tdata[1:0]);
    assign in_data = s_axis_tdata[9:2];
    assign in_col  = s_axis_tdata[16:10];
    assign in_row  = s_axis_tdata[21:17];

    // Registers and next values
    t_state            r_state,     n_state;
    logic [IDX_W-1:0]  r_idx,       n_idx;
    logic [COL_W-1:0]  r_col,       n_col;
    logic [ROW_W-1:0]  r_row,       n_row;
    logic [BYTE_W-1:0] r_text_attr;
    logic [CELL_W-1:0] r_fill_word, n_fill_word;
    logic [BYTE_W-1:0] r_put_char,  n_put_char;
    logic              r_put_after, n_put_after;
    logic              r_scrolled,  n_scrolled;
    logic [BYTE_W-1:0] r_rchar,     n_rchar;
    logic [BYTE_W-1:0] r_rattr,     n_rattr;
    logic              r_out_valid, n_out_valid;
    logic [39:0]       r_out_data,  n_out_data;

    // Screen store port
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    logic [IDX_W-1:0]  cur_index;
    logic [IDX_W-1:0]  tgt_index;
    logic              in_take;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign cur_index     = cell_index(r_row, r_col);
    assign tgt_index     = cell_index(in_row, in_col);
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Sequencer: decode commands and walk the store
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_col       = r_col;
        n_row       = r_row;
        n_fill_word = r_fill_word;
        n_put_char  = r_put_char;
        n_put_after = r_put_after;
        n_scrolled  = r_scrolled;
        n_rchar     = r_rchar;
        n_rattr     = r_rattr;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !m_axis_tready;

        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        ram_rd_addr = '0;

        case (r_state)
            // Zero every cell after reset
            S_INIT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ADDR_W'(r_idx);
                ram_wr_data = '0;
                n_idx       = r_idx + IDX_W'(1);
                if (r_idx == IDX_CLAST) begin
                    n_state = S_IDLE;
                end
            end

            // Decode one command word
            S_IDLE: begin
                if (in_take) begin
                    n_scrolled  = 1'b0;
                    n_rchar     = '0;
                    n_rattr     = '0;
                    n_put_after = 1'b0;
                    n_idx       = '0;
                    n_state     = S_DONE;
                    case (in_op)
                        OP_PUT_CHAR: begin
                            n_put_char = in_data;
                            if (in_data == NEWLINE_CODE || (in_data != NULL_CODE
                                    && r_col >= LAST_COLS)) begin
                                // Move to the next row, scroll past the bottom
                                n_col       = '0;
                                n_put_after = (in_data != NEWLINE_CODE);
                                if (r_row == LAST_ROW) begin
                                    n_scrolled = 1'b1;
                                    n_state    = S_SCROLL;
                                end else begin
                                    n_row   = ROW_W'(r_row + ROW_W'(1));
                                    n_state = (in_data != NEWLINE_CODE) ? S_PUT : S_DONE;
                                end
                            end else if (in_data != NULL_CODE) begin
                                n_state = S_PUT;
                            end
                        end
                        OP_GOTO: begin
                            n_col = (in_col > LAST_COLS) ? LAST_COLS : in_col;
                            n_row = (in_row > LAST_ROW) ? LAST_ROW : in_row;
                        end
                        OP_CLEAR: begin
                            n_fill_word = {in_data, SPACE_CODE};
                            n_state     = S_CLEAR;
                        end
                        OP_READ: begin
                            if (in_col < LAST_COLS && in_row <= LAST_ROW) begin
                                ram_rd_addr = ADDR_W'(tgt_index);
                                n_state     = S_READ;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            // Copy each cell up one row: read ahead, write behind
            S_SCROLL: begin
                ram_rd_addr = ADDR_W'(r_idx + IDX_COLS);
                if (r_idx != '0) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = ADDR_W'(r_idx - IDX_W'(1));
                    ram_wr_data = ram_rd_data;
                end
                if (r_idx == IDX_MOVE) begin
                    n_idx   = '0;
                    n_state = S_FILL;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // Blank the freed bottom row
            S_FILL: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ADDR_W'(IDX_MOVE + r_idx);
                ram_wr_data = SCROLL_WORD;
                n_idx       = r_idx + IDX_W'(1);
                if (r_idx == IDX_FLAST) begin
                    n_state = r_put_after ? S_PUT : S_DONE;
                end
            end

            // Write the character and advance the column
            S_PUT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ADDR_W'(cur_index);
                ram_wr_data = {r_text_attr, r_put_char};
                n_col       = COL_W'(r_col + COL_W'(1));
                n_state     = S_DONE;
            end

            // Fill every cell with the clear word
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ADDR_W'(r_idx);
                ram_wr_data = r_fill_word;
                n_idx       = r_idx + IDX_W'(1);
                if (r_idx == IDX_CLAST) begin
                    n_state = S_DONE;
                end
            end

            // Capture the read cell
            S_READ: begin
                n_rchar = ram_rd_data[BYTE_W-1:0];
                n_rattr = ram_rd_data[CELL_W-1:BYTE_W];
                n_state = S_DONE;
            end

            // Load the result word once the output slot is free
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_rattr, r_rchar, r_scrolled,
                                   OFF_W'(cur_index), r_row, r_col};
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, cursor, attribute and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_text_attr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_text_attr <= i_cfg_wr_data;
            end
        end
        r_fill_word <= n_fill_word;
        r_put_char  <= n_put_char;
        r_put_after <= n_put_after;
        r_scrolled  <= n_scrolled;
        r_rchar     <= n_rchar;
        r_rattr     <= n_rattr;
        r_out_data  <= n_out_data;
    end

endmodule

`default_nettype wire
